// ===== rtl/core/bel_pkg.sv =====
// Package for the bidi explicit-level block: class codes, override codes,
// the status stack entry type and the override helper. No dependencies.
package bel_pkg;

  // Bidi_Class codes used by the explicit-level rules.
  localparam logic [4:0] CLS_L   = 5'd0;
  localparam logic [4:0] CLS_R   = 5'd1;
  localparam logic [4:0] CLS_BN  = 5'd9;
  localparam logic [4:0] CLS_B   = 5'd10;
  localparam logic [4:0] CLS_LRE = 5'd14;
  localparam logic [4:0] CLS_LRO = 5'd15;
  localparam logic [4:0] CLS_RLE = 5'd16;
  localparam logic [4:0] CLS_RLO = 5'd17;
  localparam logic [4:0] CLS_PDF = 5'd18;
  localparam logic [4:0] CLS_LRI = 5'd19;
  localparam logic [4:0] CLS_RLI = 5'd20;
  localparam logic [4:0] CLS_FSI = 5'd21;
  localparam logic [4:0] CLS_PDI = 5'd22;

  // Width of an embedding level.
  localparam int unsigned LevelW = 7;

  // Directional override status of a stack entry.
  typedef enum logic [1:0] {
    OVR_NONE = 2'd0,
    OVR_L    = 2'd1,
    OVR_R    = 2'd2
  } ovr_e;

  // One entry of the directional status stack.
  typedef struct packed {
    logic [LevelW-1:0] level;
    ovr_e              ovr;
    logic              iso;
  } entry_t;

  // Rewrite a class to L or R when an override is active.
  function automatic logic [4:0] apply_ovr(input logic [4:0] cls, input ovr_e ovr);
    logic [4:0] res;
    case (ovr)
      OVR_L:   res = CLS_L;
      OVR_R:   res = CLS_R;
      default: res = cls;
    endcase
    return res;
  endfunction

endpackage

// ===== rtl/core/bel_if.sv =====
// Channel interfaces of the bidi explicit-level block: character requests,
// results and the paragraph level write. Depends on bel_pkg.
interface bel_in_if import bel_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [4:0] char_class;
  logic       fsi_is_rtl;
  logic       para_start;

  modport source(output valid, char_class, fsi_is_rtl, para_start, input ready);
  modport sink(input valid, char_class, fsi_is_rtl, para_start, output ready);
endinterface

interface bel_out_if import bel_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [LevelW-1:0] embed_level;
  logic [4:0]        working_class;

  modport source(output valid, embed_level, working_class, input ready);
  modport sink(input valid, embed_level, working_class, output ready);
endinterface

interface bel_cfg_if;
  logic valid;
  logic ready;
  logic paragraph_level;

  modport source(output valid, paragraph_level, input ready);
  modport sink(input valid, paragraph_level, output ready);
endinterface

// ===== rtl/core/bel_level_unit.sv =====
// Shared level unit: computes the next even or odd embedding level and
// whether it stays within the maximum depth. Depends on bel_pkg.
module bel_level_unit import bel_pkg::*; #(
  parameter int unsigned MAX_DEPTH = 125
) (
  input  logic [LevelW-1:0] cur_level_i,
  input  logic              rtl_i,
  output logic [LevelW-1:0] next_level_o,
  output logic              fits_o
);

  logic [LevelW:0] cur_ext;
  logic [LevelW:0] sum;

  // Next odd level for right-to-left, next even level otherwise.
  assign cur_ext = {1'b0, cur_level_i};
  always_comb begin
    if (rtl_i) begin
      sum = (cur_ext + (LevelW+1)'(1)) | (LevelW+1)'(1);
    end else begin
      sum = (cur_ext + (LevelW+1)'(2)) & ~(LevelW+1)'(1);
    end
  end

  assign next_level_o = sum[LevelW-1:0];
  assign fits_o       = (sum <= (LevelW+1)'(MAX_DEPTH));

endmodule

// ===== rtl/core/bel_stack_mem.sv =====
// Directional status stack storage: entry zero in flip-flops, the pushed
// entries in a single-port-write, registered-read memory. Depends on bel_pkg.
module bel_stack_mem import bel_pkg::*; #(
  parameter int unsigned Depth = 127
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     e0_we_i,
  input  logic [LevelW-1:0]        e0_level_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  entry_t                   wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output entry_t                   rdata_o
);

  localparam int unsigned AddrW = $clog2(Depth);

  entry_t mem_q [Depth];
  entry_t e0_q;
  entry_t rdata_q;
  logic   rd_zero_q;

  // Entry zero holds the paragraph level and is never pushed over.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e0_q <= '{level: '0, ovr: OVR_NONE, iso: 1'b0};
    end else if (e0_we_i) begin
      e0_q <= '{level: e0_level_i, ovr: OVR_NONE, iso: 1'b0};
    end
  end

  // Memory write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  // Remember whether the read targeted entry zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_zero_q <= 1'b0;
    end else if (re_i) begin
      rd_zero_q <= (raddr_i == AddrW'(0));
    end
  end

  assign rdata_o = rd_zero_q ? e0_q : rdata_q;

endmodule

// ===== rtl/core/bidi_explicit_levels.sv =====
// Bidi explicit embedding levels (rules X1 to X8), one character per request.
// Depends on bel_pkg, the bel_*_if interfaces, bel_level_unit and bel_stack_mem.
//
// A character request is first registered and then applied by the shared
// level unit and the stack sequencer in the execute state. A PDF or PDI that
// pops moves to a fetch state, where each stack entry it removes is fetched
// through the single registered read port of the status stack memory. The
// block takes a new request only while the sequencer is idle and the result
// register is empty or being emptied in that cycle. The top of stack is cached
// in flip-flops, entry zero lives in flip-flops, and the remaining MAX_DEPTH+1
// entries live in the memory, so no clearing pass is needed after reset. The
// overflow counters saturate at 65535.
module bidi_explicit_levels import bel_pkg::*; #(
  parameter int unsigned MAX_DEPTH = 125
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bel_cfg_if.sink   cfg_i,
  bel_in_if.sink    in_i,
  bel_out_if.source out_o
);

  localparam int unsigned StackSize = MAX_DEPTH + 2;
  localparam int unsigned SpW       = $clog2(StackSize);
  localparam logic [SpW-1:0] SpMax  = SpW'(StackSize - 1);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_EXEC  = 3'b010,
    ST_FETCH = 3'b100
  } state_e;

  state_e            state_q, state_d;
  logic [4:0]        cls_q;
  logic              fsi_q;
  logic [SpW-1:0]    sp_q, sp_d;
  entry_t            top_q, top_d;
  logic [15:0]       ovf_iso_q, ovf_iso_d;
  logic [15:0]       ovf_emb_q, ovf_emb_d;
  logic [6:0]        viso_q, viso_d;
  logic              par_q;
  logic              walk_q, walk_d;
  logic              out_vld_q, out_vld_d;
  logic [LevelW-1:0] out_lvl_q, out_lvl_d;
  logic [4:0]        out_cls_q, out_cls_d;

  logic              in_acc;
  logic              out_free;
  logic              rtl;
  logic [LevelW-1:0] next_lvl;
  logic              lvl_fits;
  logic              push_ok;
  logic              mem_we;
  logic              mem_re;
  logic [SpW-1:0]    mem_raddr;
  entry_t            mem_wdata;
  entry_t            fetched;

  assign cfg_i.ready = 1'b1;
  assign out_free    = !out_vld_q || out_o.ready;
  assign in_i.ready  = (state_q == ST_IDLE) && out_free;
  assign in_acc      = in_i.valid && in_i.ready;

  // Direction of the level to push, FSI taking its resolved direction.
  assign rtl = (cls_q == CLS_RLE) || (cls_q == CLS_RLO) || (cls_q == CLS_RLI) ||
               ((cls_q == CLS_FSI) && fsi_q);

  bel_level_unit #(
    .MAX_DEPTH(MAX_DEPTH)
  ) u_level (
    .cur_level_i (top_q.level),
    .rtl_i       (rtl),
    .next_level_o(next_lvl),
    .fits_o      (lvl_fits)
  );

  bel_stack_mem #(
    .Depth(StackSize)
  ) u_stack (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .e0_we_i   (in_acc && in_i.para_start),
    .e0_level_i(LevelW'(par_q)),
    .we_i      (mem_we),
    .waddr_i   (sp_q + SpW'(1)),
    .wdata_i   (mem_wdata),
    .re_i      (mem_re),
    .raddr_i   (mem_raddr),
    .rdata_o   (fetched)
  );

  assign push_ok   = lvl_fits && (ovf_iso_q == '0) && (ovf_emb_q == '0);
  assign mem_raddr = sp_q - SpW'(1);

  // Sequencer: apply one character, walking the stack for pops.
  always_comb begin
    state_d   = state_q;
    sp_d      = sp_q;
    top_d     = top_q;
    ovf_iso_d = ovf_iso_q;
    ovf_emb_d = ovf_emb_q;
    viso_d    = viso_q;
    walk_d    = walk_q;
    out_vld_d = out_vld_q && !out_o.ready;
    out_lvl_d = out_lvl_q;
    out_cls_d = out_cls_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_wdata = '{level: next_lvl, ovr: OVR_NONE, iso: 1'b0};

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_EXEC;
          if (in_i.para_start) begin
            sp_d      = '0;
            top_d     = '{level: LevelW'(par_q), ovr: OVR_NONE, iso: 1'b0};
            ovf_iso_d = '0;
            ovf_emb_d = '0;
            viso_d    = '0;
          end
        end
      end

      ST_EXEC: begin
        state_d   = ST_IDLE;
        out_vld_d = 1'b1;
        out_lvl_d = top_q.level;
        out_cls_d = cls_q;
        case (cls_q)
          CLS_LRE, CLS_RLE, CLS_LRO, CLS_RLO: begin
            if (push_ok) begin
              if (sp_q != SpMax) begin
                mem_we = 1'b1;
                if (cls_q == CLS_LRO) begin
                  mem_wdata.ovr = OVR_L;
                end else if (cls_q == CLS_RLO) begin
                  mem_wdata.ovr = OVR_R;
                end
                sp_d  = sp_q + SpW'(1);
                top_d = mem_wdata;
              end
            end else if (ovf_iso_q == '0) begin
              ovf_emb_d = (ovf_emb_q == '1) ? ovf_emb_q : ovf_emb_q + 16'd1;
            end
          end
          CLS_LRI, CLS_RLI, CLS_FSI: begin
            out_cls_d = apply_ovr(cls_q, top_q.ovr);
            if (push_ok) begin
              viso_d        = (viso_q == '1) ? viso_q : viso_q + 7'd1;
              mem_wdata.iso = 1'b1;
              if (sp_q != SpMax) begin
                mem_we = 1'b1;
                sp_d   = sp_q + SpW'(1);
                top_d  = mem_wdata;
              end
            end else begin
              ovf_iso_d = (ovf_iso_q == '1) ? ovf_iso_q : ovf_iso_q + 16'd1;
            end
          end
          CLS_PDI: begin
            out_cls_d = apply_ovr(cls_q, top_q.ovr);
            if (ovf_iso_q != '0) begin
              ovf_iso_d = ovf_iso_q - 16'd1;
            end else if (viso_q != '0) begin
              ovf_emb_d = '0;
              viso_d    = viso_q - 7'd1;
              if (sp_q != '0) begin
                // Pop and keep walking until an isolate entry is removed.
                out_vld_d = 1'b0;
                state_d   = ST_FETCH;
                mem_re    = 1'b1;
                sp_d      = sp_q - SpW'(1);
                walk_d    = !top_q.iso;
              end
            end
          end
          CLS_PDF: begin
            if (ovf_iso_q != '0) begin
              ovf_iso_d = ovf_iso_q;
            end else if (ovf_emb_q != '0) begin
              ovf_emb_d = ovf_emb_q - 16'd1;
            end else if (!top_q.iso && (sp_q != '0)) begin
              out_vld_d = 1'b0;
              state_d   = ST_FETCH;
              mem_re    = 1'b1;
              sp_d      = sp_q - SpW'(1);
              walk_d    = 1'b0;
            end
          end
          CLS_B: begin
            out_lvl_d = LevelW'(par_q);
          end
          CLS_BN: begin
            out_cls_d = cls_q;
          end
          default: begin
            out_cls_d = apply_ovr(cls_q, top_q.ovr);
          end
        endcase
      end

      ST_FETCH: begin
        top_d = fetched;
        if (walk_q && (sp_q != '0)) begin
          // Still inside non-isolate entries: pop one more.
          mem_re = 1'b1;
          sp_d   = sp_q - SpW'(1);
          walk_d = !fetched.iso;
        end else begin
          state_d   = ST_IDLE;
          out_vld_d = 1'b1;
          out_lvl_d = fetched.level;
          out_cls_d = (cls_q == CLS_PDI) ? apply_ovr(cls_q, fetched.ovr) : cls_q;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control and stack state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      sp_q      <= '0;
      top_q     <= '{level: '0, ovr: OVR_NONE, iso: 1'b0};
      ovf_iso_q <= '0;
      ovf_emb_q <= '0;
      viso_q    <= '0;
      par_q     <= 1'b0;
      walk_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      sp_q      <= sp_d;
      top_q     <= top_d;
      ovf_iso_q <= ovf_iso_d;
      ovf_emb_q <= ovf_emb_d;
      viso_q    <= viso_d;
      walk_q    <= walk_d;
      out_vld_q <= out_vld_d;
      if (cfg_i.valid) begin
        par_q <= cfg_i.paragraph_level;
      end
    end
  end

  // Request and result payload registers.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cls_q <= in_i.char_class;
      fsi_q <= in_i.fsi_is_rtl;
    end
    out_lvl_q <= out_lvl_d;
    out_cls_q <= out_cls_d;
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.embed_level   = out_lvl_q;
  assign out_o.working_class = out_cls_q;

  // The stack pointer stays inside the stack.
  a_sp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SpMax)
    else $error("stack pointer beyond the stack");

  // A pending result only exists while the sequencer is idle.
  a_out_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (state_q == ST_IDLE))
    else $error("result pending while the sequencer is busy");

  // An accepted request is executed in the next cycle.
  a_acc_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ST_EXEC))
    else $error("accepted request not executed");

  // A PDF inside an overflowed isolate leaves the stack alone.
  a_pdf_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC && cls_q == CLS_PDF && ovf_iso_q != '0) |=> $stable(sp_q))
    else $error("PDF popped during isolate overflow");

endmodule
